@@ src/rbde_pkg.sv @@
// ----------------------------------------------------------------------------
// rbde_pkg
// Shared types and constants of the recurrence-base digit expander.
// ----------------------------------------------------------------------------
package rbde_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 48;

  localparam int NUMBER_W   = 32;
  localparam int DIGIT_W    = 10;
  localparam int PLACE_W    = 6;
  localparam int COEF_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int TDATA_W    = 16;

  localparam int TBL_ADDR_MAX_W = 6;
  localparam int VALUE_MAX_W    = 64;

  localparam logic [VALUE_MAX_W-1:0] DIGIT_MAX = 64'd1023;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_FIRST  = 3'd0,
    REG_COEF_SECOND = 3'd1,
    REG_COEF_THIRD  = 3'd2,
    REG_COEF_FOURTH = 3'd3,
    REG_FOUR_TERM   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    BLD_RUN,
    BLD_DONE
  } build_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DESC_RD,
    ST_DESC_CHK,
    ST_DIV,
    ST_EMIT,
    ST_FLUSH
  } back_state_t;

  // weight table write from the builder
  typedef struct packed {
    logic                      we;
    logic [TBL_ADDR_MAX_W-1:0] addr;
    logic [VALUE_MAX_W-1:0]    data;
  } tbl_wr_t;

endpackage

@@ src/rbde_build.sv @@
// ----------------------------------------------------------------------------
// rbde_build
// Configuration registers and weight table builder, one product per cycle.
// ----------------------------------------------------------------------------
module rbde_build #(
  parameter int VALUE_WIDTH = rbde_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rbde_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rbde_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rbde_pkg::COEF_W-1:0]         cfg_wdata,
  output rbde_pkg::tbl_wr_t                   tbl_wr,
  output logic                                busy
);

  localparam int PW = $clog2(MAX_DIGITS + 1);
  localparam int CW = rbde_pkg::COEF_W + 1;
  localparam logic [VALUE_WIDTH-1:0] VMAX = {VALUE_WIDTH{1'b1}};

  rbde_pkg::build_state_t state, state_next;

  logic [rbde_pkg::COEF_W-1:0] c1, c2, c3, c4;
  logic                        mode;
  logic [PW-1:0]               idx;
  logic [2:0]                  term;
  logic [VALUE_WIDTH-1:0]      acc;
  logic [VALUE_WIDTH-1:0]      hist [4];

  logic                        cfg_hit;
  logic [2:0]                  nterms;
  logic [CW-1:0]               coef;
  logic [VALUE_WIDTH-1:0]      hsel;
  logic [VALUE_WIDTH+CW-1:0]   prod;
  logic [VALUE_WIDTH-1:0]      prod_sat;
  logic [VALUE_WIDTH:0]        sum;
  logic                        entry_done;
  logic [PW-1:0]               idx_inc;

  always_comb begin
    unique case (rbde_pkg::cfg_reg_t'(cfg_addr))
      rbde_pkg::REG_COEF_FIRST, rbde_pkg::REG_COEF_SECOND, rbde_pkg::REG_COEF_THIRD,
      rbde_pkg::REG_COEF_FOURTH, rbde_pkg::REG_FOUR_TERM: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign idx_inc = idx + PW'(1);

  // term schedule of the current entry
  always_comb begin
    if (idx == PW'(0)) begin
      nterms = 3'd0;
      coef   = '0;
    end else if (idx == PW'(1)) begin
      nterms = 3'd1;
      coef   = CW'(c1);
    end else if (idx == PW'(2)) begin
      nterms = 3'd1;
      coef   = CW'(c2) + CW'(1);
    end else if (idx == PW'(3) && mode) begin
      nterms = 3'd2;
      coef   = (term == 3'd0) ? CW'(1) : CW'(c3);
    end else if (mode) begin
      nterms = 3'd4;
      case (term)
        3'd0:    coef = CW'(c4);
        3'd1:    coef = CW'(c3);
        3'd2:    coef = CW'(c2);
        default: coef = CW'(c1);
      endcase
    end else begin
      nterms = 3'd3;
      case (term)
        3'd0:    coef = CW'(c3);
        3'd1:    coef = CW'(c2);
        default: coef = CW'(c1);
      endcase
    end
  end

  assign hsel       = hist[term[1:0]];
  assign prod       = (VALUE_WIDTH+CW)'(coef) * (VALUE_WIDTH+CW)'(hsel);
  assign prod_sat   = (prod[VALUE_WIDTH+CW-1:VALUE_WIDTH] != '0) ? VMAX
                                                                 : prod[VALUE_WIDTH-1:0];
  assign sum        = {1'b0, acc} + {1'b0, prod_sat};
  assign entry_done = (term == nterms);

  // a register write restarts the build from any state
  always_comb begin
    unique case (state)
      rbde_pkg::BLD_RUN:  state_next = (entry_done && idx == PW'(MAX_DIGITS - 1))
                                       ? rbde_pkg::BLD_DONE : rbde_pkg::BLD_RUN;
      rbde_pkg::BLD_DONE: state_next = rbde_pkg::BLD_DONE;
      default:            state_next = rbde_pkg::BLD_DONE;
    endcase
    if (cfg_hit) state_next = rbde_pkg::BLD_RUN;
  end

  always_comb begin
    busy        = (state == rbde_pkg::BLD_RUN);
    tbl_wr.we   = busy && entry_done;
    tbl_wr.addr = rbde_pkg::TBL_ADDR_MAX_W'(idx);
    tbl_wr.data = rbde_pkg::VALUE_MAX_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbde_pkg::BLD_RUN;
      c1    <= rbde_pkg::COEF_W'(1);
      c2    <= rbde_pkg::COEF_W'(1);
      c3    <= rbde_pkg::COEF_W'(1);
      c4    <= rbde_pkg::COEF_W'(1);
      mode  <= 1'b0;
      idx   <= '0;
      term  <= '0;
      acc   <= VALUE_WIDTH'(1);
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        unique case (rbde_pkg::cfg_reg_t'(cfg_addr))
          rbde_pkg::REG_COEF_FIRST:  c1   <= cfg_wdata;
          rbde_pkg::REG_COEF_SECOND: c2   <= cfg_wdata;
          rbde_pkg::REG_COEF_THIRD:  c3   <= cfg_wdata;
          rbde_pkg::REG_COEF_FOURTH: c4   <= cfg_wdata;
          rbde_pkg::REG_FOUR_TERM:   mode <= cfg_wdata[0];
          default: ;
        endcase
        idx  <= '0;
        term <= '0;
        acc  <= VALUE_WIDTH'(1);
      end else if (state == rbde_pkg::BLD_RUN) begin
        if (entry_done) begin
          idx  <= idx_inc;
          term <= '0;
          acc  <= (idx_inc == PW'(1)) ? VALUE_WIDTH'(1) : '0;
        end else begin
          term <= term + 3'd1;
          acc  <= sum[VALUE_WIDTH] ? VMAX : sum[VALUE_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rbde_pkg::BLD_RUN && entry_done) begin
      hist[3] <= hist[2];
      hist[2] <= hist[1];
      hist[1] <= hist[0];
      hist[0] <= acc;
    end
  end

endmodule

@@ src/rbde_front.sv @@
// ----------------------------------------------------------------------------
// rbde_front
// Input side: accepts numbers, clamps them to the value range, drops zeros.
// ----------------------------------------------------------------------------
module rbde_front #(
  parameter int VALUE_WIDTH = rbde_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rbde_pkg::NUMBER_W-1:0]  s_tdata,
  input  logic                           table_busy,
  input  logic                           q_ready,
  output logic                           q_push,
  output logic [VALUE_WIDTH-1:0]         q_data
);

  localparam logic [VALUE_WIDTH-1:0] VMAX = {VALUE_WIDTH{1'b1}};

  logic [rbde_pkg::VALUE_MAX_W-1:0] wide;

  assign wide     = rbde_pkg::VALUE_MAX_W'(s_tdata);
  assign s_tready = q_ready && !table_busy;
  // a zero number has no digits
  assign q_push   = s_tvalid && s_tready && (s_tdata != '0);
  assign q_data   = (wide > rbde_pkg::VALUE_MAX_W'(VMAX)) ? VMAX : wide[VALUE_WIDTH-1:0];

endmodule

@@ src/rbde_fifo.sv @@
// ----------------------------------------------------------------------------
// rbde_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module rbde_fifo #(
  parameter int WIDTH = rbde_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr, rptr;
  logic [1:0]       count;

  assign ready    = (count != 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

@@ src/rbde_back.sv @@
// ----------------------------------------------------------------------------
// rbde_back
// Weight table, position search, bit-serial divider and digit output.
// ----------------------------------------------------------------------------
module rbde_back #(
  parameter int VALUE_WIDTH = rbde_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rbde_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rbde_pkg::tbl_wr_t               tbl_wr,
  input  logic                            q_valid,
  input  logic [VALUE_WIDTH-1:0]          q_data,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rbde_pkg::TDATA_W-1:0]    m_tdata,
  output logic                            m_tlast
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int PW = $clog2(MAX_DIGITS + 1);
  localparam int BW = $clog2(VALUE_WIDTH);

  rbde_pkg::back_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] mem [MAX_DIGITS];
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic [VALUE_WIDTH-1:0] rem, wp, dv, quo, rmd;
  logic [PW-1:0]          p;
  logic                   skip;
  logic [BW-1:0]          bitc;

  logic                       pend_v;
  logic [rbde_pkg::TDATA_W-1:0] pend_data;
  logic                       out_free;

  logic [PW-1:0]              p_inc, p_dec;
  logic [VALUE_WIDTH:0]       trial, diff;
  logic                       ge;
  logic [VALUE_WIDTH-1:0]     rmd_n;
  logic [rbde_pkg::VALUE_MAX_W-1:0] quo_w;
  logic [rbde_pkg::DIGIT_W-1:0] digit_v;
  logic                       emit_go, flush_go;
  logic                       load_out;

  assign p_inc    = p + PW'(1);
  assign p_dec    = p - PW'(1);
  assign out_free = !m_tvalid || m_tready;
  assign emit_go  = !pend_v || out_free;
  assign flush_go = !pend_v || out_free;
  assign load_out = pend_v && ((state == rbde_pkg::ST_EMIT && emit_go) ||
                               (state == rbde_pkg::ST_FLUSH && flush_go));

  // one restoring division step
  assign trial = {rmd, quo[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dv};
  assign ge    = !diff[VALUE_WIDTH];
  assign rmd_n = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];

  assign quo_w   = rbde_pkg::VALUE_MAX_W'(quo);
  assign digit_v = (quo_w > rbde_pkg::DIGIT_MAX) ? rbde_pkg::DIGIT_W'(rbde_pkg::DIGIT_MAX)
                                                 : quo_w[rbde_pkg::DIGIT_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      rbde_pkg::ST_IDLE:     if (q_valid) state_next = rbde_pkg::ST_SRCH_RD;
      rbde_pkg::ST_SRCH_RD:  state_next = rbde_pkg::ST_SRCH_CMP;
      rbde_pkg::ST_SRCH_CMP: state_next = (rd_data <= rem && p_inc != PW'(MAX_DIGITS))
                                          ? rbde_pkg::ST_SRCH_RD : rbde_pkg::ST_DESC_RD;
      rbde_pkg::ST_DESC_RD:  state_next = rbde_pkg::ST_DESC_CHK;
      rbde_pkg::ST_DESC_CHK: begin
        if (skip) begin
          state_next = (p_dec == '0) ? rbde_pkg::ST_FLUSH : rbde_pkg::ST_DESC_RD;
        end else if (rd_data == '0) begin
          state_next = rbde_pkg::ST_EMIT;
        end else begin
          state_next = rbde_pkg::ST_DIV;
        end
      end
      rbde_pkg::ST_DIV:      if (bitc == '0) state_next = rbde_pkg::ST_EMIT;
      rbde_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_next = (p_dec == '0) ? rbde_pkg::ST_FLUSH : rbde_pkg::ST_DESC_RD;
        end
      end
      rbde_pkg::ST_FLUSH:    if (flush_go) state_next = rbde_pkg::ST_IDLE;
      default:               state_next = rbde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = (state == rbde_pkg::ST_IDLE) && q_valid;
    rd_addr = (state == rbde_pkg::ST_DESC_RD) ? p_dec[AW-1:0] : p[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (tbl_wr.we) mem[tbl_wr.addr[AW-1:0]] <= tbl_wr.data[VALUE_WIDTH-1:0];
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rbde_pkg::ST_IDLE;
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == rbde_pkg::ST_EMIT && emit_go) begin
        pend_v <= 1'b1;
      end
      if (state == rbde_pkg::ST_FLUSH && flush_go) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rbde_pkg::ST_IDLE: begin
        rem <= q_data;
        p   <= '0;
      end
      rbde_pkg::ST_SRCH_CMP: begin
        if (rd_data <= rem) p <= p_inc;
        else                wp <= rd_data;
      end
      rbde_pkg::ST_DESC_RD: skip <= (p != PW'(MAX_DIGITS)) && (wp <= rem);
      rbde_pkg::ST_DESC_CHK: begin
        wp <= rd_data;
        if (skip) begin
          p <= p_dec;
        end else if (rd_data == '0) begin
          quo <= '0;
        end else begin
          quo  <= rem;
          dv   <= rd_data;
          rmd  <= '0;
          bitc <= BW'(VALUE_WIDTH - 1);
        end
      end
      rbde_pkg::ST_DIV: begin
        rmd  <= rmd_n;
        quo  <= {quo[VALUE_WIDTH-2:0], ge};
        bitc <= bitc - BW'(1);
        if (bitc == '0) rem <= rmd_n;
      end
      rbde_pkg::ST_EMIT: begin
        if (emit_go) begin
          pend_data <= {rbde_pkg::PLACE_W'(p_dec), digit_v};
          p         <= p_dec;
          if (pend_v) begin
            m_tdata <= pend_data;
            m_tlast <= 1'b0;
          end
        end
      end
      rbde_pkg::ST_FLUSH: begin
        if (flush_go && pend_v) begin
          m_tdata <= pend_data;
          m_tlast <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/recurrence_base_digit_expander_unit.sv @@
// ----------------------------------------------------------------------------
// recurrence_base_digit_expander_unit
// Greedy digit expansion of a number over recurrence-defined place weights.
// ----------------------------------------------------------------------------
// Each number is expanded into digits most significant first, with tlast on
// the final digit; zero yields no transaction. After reset and after every
// register write the weight table is rebuilt, one product per cycle, and
// s_axis_tready stays low meanwhile. An item first reads the table upward to
// find its top position, then walks the positions down and runs the divider
// for each digit, with the pace set by the one-bit-per-cycle divider and the
// single table read port.
module recurrence_base_digit_expander_unit #(
  parameter int VALUE_WIDTH = rbde_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rbde_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rbde_pkg::NUMBER_W-1:0]     s_axis_tdata,   // number_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rbde_pkg::TDATA_W-1:0]      m_axis_tdata,   // digit, place
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [rbde_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rbde_pkg::COEF_W-1:0]       cfg_wdata
);

  rbde_pkg::tbl_wr_t      tbl_wr;
  logic                   busy;
  logic                   q_ready, q_push, q_valid, q_pop;
  logic [VALUE_WIDTH-1:0] q_in, q_out;

  rbde_build #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_DIGITS(MAX_DIGITS)) u_build (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .tbl_wr(tbl_wr), .busy(busy)
  );

  rbde_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
    .table_busy(busy), .q_ready(q_ready), .q_push(q_push), .q_data(q_in)
  );

  rbde_fifo #(.WIDTH(VALUE_WIDTH)) u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .pop_data(q_out)
  );

  rbde_back #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk(clk), .rst(rst), .tbl_wr(tbl_wr), .q_valid(q_valid), .q_data(q_out),
    .q_pop(q_pop), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata), .m_tlast(m_axis_tlast)
  );

endmodule

@@ dv/recurrence_base_digit_expander_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recurrence_base_digit_expander_unit_test
// Self-checking bench for the recurrence-base digit expander: a directed
// table, then random numbers under several coefficient settings, each
// digit transaction compared against a typed row or an in-bench greedy expansion.
// ----------------------------------------------------------------------------
module recurrence_base_digit_expander_unit_test;

  localparam logic [63:0] SAT_MAX = 64'hFFFF_FFFF;
  localparam int NUM_PLACES = 48;
  localparam int SETTLE_CYCLES = 2500;
  localparam logic [rbde_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd5;

  typedef struct {
    logic [rbde_pkg::DIGIT_W-1:0] digit;
    logic [rbde_pkg::PLACE_W-1:0] place;
    logic                         last;
  } digit_t;

  typedef struct {
    logic [31:0]                  number;
    bit                           typed;
    int                           count;
    logic [rbde_pkg::DIGIT_W-1:0] digit;
    logic [rbde_pkg::PLACE_W-1:0] place;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [rbde_pkg::NUMBER_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [rbde_pkg::TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 0;
  logic [rbde_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [rbde_pkg::COEF_W-1:0] cfg_wdata = '0;

  logic [63:0] place_weight[NUM_PLACES];
  logic [7:0] coef[4];
  logic four_term;
  digit_t pending_digits[$];
  int errors = 0;
  bit no_idle = 0;
  bit hold_request = 0;

  recurrence_base_digit_expander_unit uut (.*);

  always #4 clk = ~clk;

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    return (a + b > SAT_MAX) ? SAT_MAX : a + b;
  endfunction

  function automatic logic [63:0] sat_mul(input logic [63:0] c, input logic [63:0] w);
    return (c * w > SAT_MAX) ? SAT_MAX : c * w;
  endfunction

  function automatic void rebuild_weights();
    int first;
    logic [63:0] s;
    place_weight[0] = 1;
    place_weight[1] = sat_add(coef[0], 1);
    place_weight[2] = sat_mul(coef[1] + 64'd1, place_weight[1]);
    first = 3;
    if (four_term) begin
      place_weight[3] = sat_add(place_weight[2], sat_mul(coef[2], place_weight[1]));
      first = 4;
    end
    for (int i = first; i < NUM_PLACES; i++) begin
      if (four_term) begin
        s = sat_mul(coef[3], place_weight[i-1]);
        s = sat_add(s, sat_mul(coef[2], place_weight[i-2]));
        s = sat_add(s, sat_mul(coef[1], place_weight[i-3]));
        s = sat_add(s, sat_mul(coef[0], place_weight[i-4]));
      end else begin
        s = sat_mul(coef[2], place_weight[i-1]);
        s = sat_add(s, sat_mul(coef[1], place_weight[i-2]));
        s = sat_add(s, sat_mul(coef[0], place_weight[i-3]));
      end
      place_weight[i] = s;
    end
  endfunction

  // greedy expansion, most significant digit first
  function automatic void expand_number(input logic [31:0] n);
    logic [63:0] rem, w, q;
    int k, p;
    digit_t d;
    digit_t digits[$];
    rem = 64'(n);
    k = 0;
    while (k < NUM_PLACES && place_weight[k] <= rem) k++;
    for (p = k; p > 0; p--) begin
      if (p < NUM_PLACES && place_weight[p] <= rem) continue;
      w = place_weight[p-1];
      q = (w != 0) ? rem / w : 0;
      if (w != 0) rem = rem % w;
      d.digit = (q > 1023) ? 10'd1023 : q[rbde_pkg::DIGIT_W-1:0];
      d.place = rbde_pkg::PLACE_W'(p - 1);
      d.last = 0;
      digits.push_back(d);
    end
    if (digits.size() > 0) digits[$].last = 1;
    foreach (digits[i]) pending_digits.push_back(digits[i]);
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // receiver with random stalls and one long hold-off
  int stall_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    digit_t want;
    logic ready_next;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_digits.size() == 0) begin
          report($sformatf("unexpected digit transaction %h", m_axis_tdata));
        end else begin
          want = pending_digits.pop_front();
          if (m_axis_tdata[rbde_pkg::DIGIT_W-1:0] !== want.digit)
            report($sformatf("digit %0d, want %0d", m_axis_tdata[rbde_pkg::DIGIT_W-1:0],
                             want.digit));
          if (m_axis_tdata[rbde_pkg::DIGIT_W +: rbde_pkg::PLACE_W] !== want.place)
            report($sformatf("place %0d, want %0d",
                             m_axis_tdata[rbde_pkg::DIGIT_W +: rbde_pkg::PLACE_W],
                             want.place));
          if (m_axis_tlast !== want.last)
            report($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 18);
      end
      if (hold_request && !hold_done) begin
        hold_done = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 0;
      end else begin
        ready_next = 1;
      end
      m_axis_tready <= ready_next;
    end
  end

  task automatic send_number(input logic [31:0] n, input bit typed = 0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= n;
    do @(posedge clk); while (!s_axis_tready);
    if (!typed) expand_number(n);
  endtask

  task automatic write_reg(input logic [rbde_pkg::CFG_ADDR_W-1:0] idx, input logic [7:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] c1, input logic [7:0] c2,
                               input logic [7:0] c3, input logic [7:0] c4,
                               input logic mode);
    s_axis_tvalid <= 0;
    wait (pending_digits.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(rbde_pkg::REG_COEF_FIRST, c1);
    write_reg(rbde_pkg::REG_COEF_SECOND, c2);
    write_reg(rbde_pkg::REG_COEF_THIRD, c3);
    write_reg(rbde_pkg::REG_COEF_FOURTH, c4);
    write_reg(rbde_pkg::REG_FOUR_TERM, {7'd0, mode});
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_we <= 0;
    coef[0] = c1;
    coef[1] = c2;
    coef[2] = c3;
    coef[3] = c4;
    four_term = mode;
    rebuild_weights();
  endtask

  function automatic logic [31:0] random_number();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom;
    if (pick < 6) return 32'(place_weight[$urandom_range(0, NUM_PLACES-1)] +
                             64'($urandom_range(0, 2)) - 64'd1);
    if (pick < 8) return $urandom_range(1, 1000);
    if (pick == 8) return 32'hFFFF_FFFF >> $urandom_range(0, 31);
    return 32'd0;
  endfunction

  row_t directed[] = '{
    '{32'd1, 1, 1, 10'd1, 6'd0},
    '{32'd0, 1, 0, 10'd0, 6'd0},
    '{32'd2, 0, 0, 0, 0}, '{32'd3, 0, 0, 0, 0}, '{32'd4, 0, 0, 0, 0},
    '{32'd6, 0, 0, 0, 0}, '{32'd7, 0, 0, 0, 0}, '{32'd12, 0, 0, 0, 0},
    '{32'd13, 0, 0, 0, 0}, '{32'd100, 0, 0, 0, 0},
    '{32'hFFFF_FFFF, 0, 0, 0, 0}, '{32'h8000_0000, 0, 0, 0, 0},
    '{32'h7FFF_FFFF, 0, 0, 0, 0}, '{32'hAAAA_AAAA, 0, 0, 0, 0},
    '{32'h5555_5555, 0, 0, 0, 0}
  };

  initial begin
    digit_t d;
    coef = '{8'd1, 8'd1, 8'd1, 8'd1};
    four_term = 0;
    rebuild_weights();
    repeat (2) @(posedge clk);
    rst <= 0;

    foreach (directed[i]) begin
      if (directed[i].typed && directed[i].count > 0) begin
        d.digit = directed[i].digit;
        d.place = directed[i].place;
        d.last = 1;
        pending_digits.push_back(d);
      end
      send_number(directed[i].number, directed[i].typed);
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        1: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        2: apply_setting(8'd1, 8'd1, 8'd1, 8'd1, 1'b1);
        3: apply_setting(8'd1, 8'd1, 8'd1, 8'd1, 1'b0);
        default: apply_setting(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                               8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                               ph[0]);
      endcase
      no_idle = (ph == 2);
      for (int n = 0; n < 51; n++) begin
        if (ph == 1 && n == 5) hold_request = 1;
        send_number(random_number());
      end
      no_idle = 0;
    end
    s_axis_tvalid <= 0;

    wait (pending_digits.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
